FILE: src/tbp_pkg.sv
`default_nettype none

package tbp_pkg;

    localparam int PC_INDEX_BITS_DEF       = 10;
    localparam int LOCAL_HISTORY_BITS_DEF  = 11;
    localparam int GLOBAL_HISTORY_BITS_DEF = 12;

    // 2-bit counter codes
    localparam logic [1:0] CTR_STRONG_NT      = 2'd0;
    localparam logic [1:0] CTR_STRONG_T       = 2'd3;
    localparam logic [1:0] CHOOSER_WEAK_LOCAL = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CALC
    } tbp_state_t;

    function automatic logic [1:0] sat_move(input logic [1:0] ctr, input logic up);
        logic [1:0] res;
        res = ctr;
        if (up)
        begin
            if (ctr != CTR_STRONG_T)
            begin
                res = ctr + 2'd1;
            end
        end
        else
        begin
            if (ctr != CTR_STRONG_NT)
            begin
                res = ctr - 2'd1;
            end
        end
        return res;
    endfunction

    // Upper bit set: counter says taken, chooser says local.
    function automatic logic ctr_high(input logic [1:0] ctr);
        return ctr[1];
    endfunction

endpackage

`default_nettype wire

FILE: src/tbp_ram.sv
`default_nettype none

module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Hold read data until the next read.
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/tournament_branch_predictor_core.sv
`default_nettype none

// Channel   Ports                          Transfer when
// input     in_valid in_stall action pc   in_valid && !in_stall
//           outcome
// output    out_valid out_stall prediction out_valid && !out_stall
//
// Each item passes transfer (history, global and chooser reads), then the
// local counter read, then prediction and write-back. The local counter read
// depends on the history read, so the two reads come one after the other.
// After reset a clearing pass steps through every table address and writes
// reset values; in_stall stays high meanwhile.
// A stalled result holds the write-back cycle; a new item is taken while the
// result waits.

module tournament_branch_predictor_core
    import tbp_pkg::*;
#(
    parameter int PC_INDEX_BITS       = PC_INDEX_BITS_DEF,
    parameter int LOCAL_HISTORY_BITS  = LOCAL_HISTORY_BITS_DEF,
    parameter int GLOBAL_HISTORY_BITS = GLOBAL_HISTORY_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [31:0] pc,
    input  wire logic        outcome,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             prediction
);

    localparam int PC_B  = PC_INDEX_BITS;
    localparam int LH_B  = LOCAL_HISTORY_BITS;
    localparam int GH_B  = GLOBAL_HISTORY_BITS;
    localparam int MAX_A = (PC_B > LH_B) ? PC_B : LH_B;
    localparam int CLR_B = (MAX_A > GH_B) ? MAX_A : GH_B;

    tbp_state_t state_reg, state_next;

    logic [CLR_B-1:0] clr_reg, clr_next;
    logic [GH_B-1:0]  gh_reg, gh_next;
    logic [PC_B-1:0]  pidx_reg;
    logic [GH_B-1:0]  gidx_reg;
    logic             action_reg;
    logic             outcome_reg;
    logic             out_valid_reg, out_valid_next;
    logic             pred_reg;

    logic             accept;
    logic             calc_go;
    logic             clr_we;
    logic             upd_we;
    logic             lht_re;
    logic             glb_re;
    logic             lc_re;

    logic [LH_B-1:0]  lht_rdata;
    logic [1:0]       lc_rdata;
    logic [1:0]       gc_rdata;
    logic [1:0]       ch_rdata;

    logic             local_taken;
    logic             global_taken;
    logic             pred;
    logic             local_right;
    logic             global_right;
    logic [1:0]       ch_new;
    logic [LH_B-1:0]  lh_new;

    logic             mem_we;
    logic [PC_B-1:0]  lht_waddr;
    logic [LH_B-1:0]  lht_wdata;
    logic [LH_B-1:0]  lc_waddr;
    logic [1:0]       lc_wdata;
    logic [GH_B-1:0]  gc_waddr;
    logic [1:0]       gc_wdata;
    logic [GH_B-1:0]  ch_waddr;
    logic [1:0]       ch_wdata;
    logic [GH_B-1:0]  gidx_in;

    assign gidx_in = pc[GH_B-1:0] ^ gh_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HIST;
                end
            end
            ST_HIST:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (calc_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        clr_we   = 1'b0;
        lht_re   = 1'b0;
        glb_re   = 1'b0;
        lc_re    = 1'b0;
        calc_go  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_we = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                lht_re   = in_valid;
                glb_re   = in_valid;
            end
            ST_HIST:
            begin
                lc_re = 1'b1;
            end
            ST_CALC:
            begin
                calc_go = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;
    assign upd_we = calc_go && action_reg;
    assign mem_we = clr_we || upd_we;

    // Prediction and training values
    assign local_taken  = ctr_high(lc_rdata);
    assign global_taken = ctr_high(gc_rdata);
    assign pred         = ctr_high(ch_rdata) ? local_taken : global_taken;
    assign local_right  = (local_taken == outcome_reg);
    assign global_right = (global_taken == outcome_reg);
    assign lh_new       = LH_B'({lht_rdata, outcome_reg});

    always_comb
    begin
        ch_new = ch_rdata;
        if (local_right && !global_right)
        begin
            ch_new = sat_move(ch_rdata, 1'b1);
        end
        else if (global_right && !local_right)
        begin
            ch_new = sat_move(ch_rdata, 1'b0);
        end
    end

    // Write port select: clearing pass or write-back
    always_comb
    begin
        if (clr_we)
        begin
            lht_waddr = clr_reg[PC_B-1:0];
            lht_wdata = '0;
            lc_waddr  = clr_reg[LH_B-1:0];
            lc_wdata  = CTR_STRONG_NT;
            gc_waddr  = clr_reg[GH_B-1:0];
            gc_wdata  = CTR_STRONG_NT;
            ch_waddr  = clr_reg[GH_B-1:0];
            ch_wdata  = CHOOSER_WEAK_LOCAL;
        end
        else
        begin
            lht_waddr = pidx_reg;
            lht_wdata = lh_new;
            lc_waddr  = lht_rdata;
            lc_wdata  = sat_move(lc_rdata, outcome_reg);
            gc_waddr  = gidx_reg;
            gc_wdata  = sat_move(gc_rdata, outcome_reg);
            ch_waddr  = gh_reg;
            ch_wdata  = ch_new;
        end
    end

    always_comb
    begin
        clr_next = clr_reg;
        if (clr_we)
        begin
            clr_next = clr_reg + CLR_B'(1);
        end
        gh_next = gh_reg;
        if (upd_we)
        begin
            gh_next = GH_B'({gh_reg, outcome_reg});
        end
        out_valid_next = out_valid_reg;
        if (calc_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            gh_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            gh_reg        <= gh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pidx_reg    <= pc[PC_B-1:0];
            gidx_reg    <= gidx_in;
            action_reg  <= action;
            outcome_reg <= outcome;
        end
        if (calc_go)
        begin
            pred_reg <= pred;
        end
    end

    assign out_valid  = out_valid_reg;
    assign prediction = pred_reg;

    tbp_ram #(.WIDTH(LH_B), .DEPTH(2 ** PC_B)) u_lht (
        .clk   (clk),
        .we    (mem_we),
        .waddr (lht_waddr),
        .wdata (lht_wdata),
        .re    (lht_re),
        .raddr (pc[PC_B-1:0]),
        .rdata (lht_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2 ** LH_B)) u_lc (
        .clk   (clk),
        .we    (mem_we),
        .waddr (lc_waddr),
        .wdata (lc_wdata),
        .re    (lc_re),
        .raddr (lht_rdata),
        .rdata (lc_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2 ** GH_B)) u_gc (
        .clk   (clk),
        .we    (mem_we),
        .waddr (gc_waddr),
        .wdata (gc_wdata),
        .re    (glb_re),
        .raddr (gidx_in),
        .rdata (gc_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2 ** GH_B)) u_ch (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .re    (glb_re),
        .raddr (gh_reg),
        .rdata (ch_rdata)
    );

`ifndef SYNTHESIS
    a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("input transfer open during clearing pass");

    a_transfer_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_HIST) ##1 (state_reg == ST_CALC))
        else $error("lookup sequence broken after input transfer");

    a_write_only_on_train: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !clr_we) |-> (state_reg == ST_CALC && action_reg))
        else $error("table write outside training write-back");

    a_history_still_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(gh_reg))
        else $error("global history changed without training");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !calc_go)
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_tournament_branch_predictor_core.sv
`timescale 1ns / 1ps

module tb_tournament_branch_predictor_core;
    import tbp_pkg::*;

    localparam int PCB = PC_INDEX_BITS_DEF;
    localparam int LHB = LOCAL_HISTORY_BITS_DEF;
    localparam int GHB = GLOBAL_HISTORY_BITS_DEF;

    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_TRAIN   = 1'b1;
    localparam logic NOT_TAKEN   = 1'b0;
    localparam logic TAKEN       = 1'b1;

    localparam int HOT_BRANCHES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = ACT_PREDICT;
    logic [31:0] pc = 32'd0;
    logic        outcome = NOT_TAKEN;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        prediction;

    // Shadow copy of the predictor tables
    logic [LHB-1:0] local_hist [1 << PCB];
    logic [1:0]     local_ctr  [1 << LHB];
    logic [1:0]     global_ctr [1 << GHB];
    logic [1:0]     chooser    [1 << GHB];
    logic [GHB-1:0] global_hist;

    logic expected_dir_q [$];
    int   err_count = 0;
    int   send_idle_pct = 0;
    int   out_stall_pct = 0;

    logic [31:0] hot_pc   [HOT_BRANCHES];
    int          hot_step [HOT_BRANCHES];

    tournament_branch_predictor_core #(
        .PC_INDEX_BITS      (PCB),
        .LOCAL_HISTORY_BITS (LHB),
        .GLOBAL_HISTORY_BITS(GHB)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .pc        (pc),
        .outcome   (outcome),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .prediction(prediction)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [1:0] step_ctr(input logic [1:0] c, input logic up);
        if (up)
        begin
            return (c == CTR_STRONG_T) ? c : c + 2'd1;
        end
        return (c == CTR_STRONG_NT) ? c : c - 2'd1;
    endfunction

    function automatic void clear_tables();
        foreach (local_hist[i]) local_hist[i] = '0;
        foreach (local_ctr[i]) local_ctr[i] = CTR_STRONG_NT;
        foreach (global_ctr[i]) global_ctr[i] = CTR_STRONG_NT;
        foreach (chooser[i]) chooser[i] = CHOOSER_WEAK_LOCAL;
        global_hist = '0;
    endfunction

    // Return the direction from the current tables, then train if asked
    function automatic logic predict_branch(input logic act, input logic [31:0] addr,
                                            input logic taken);
        logic [PCB-1:0] pidx;
        logic [LHB-1:0] lh;
        logic [GHB-1:0] gidx;
        logic [GHB-1:0] cidx;
        logic [1:0]     lc;
        logic [1:0]     gc;
        logic [1:0]     ch;
        logic           loc_taken;
        logic           glb_taken;
        logic           dir;
        pidx = addr[PCB-1:0];
        lh   = local_hist[pidx];
        gidx = addr[GHB-1:0] ^ global_hist;
        cidx = global_hist;
        lc   = local_ctr[lh];
        gc   = global_ctr[gidx];
        ch   = chooser[cidx];
        loc_taken = (lc >= 2'd2);
        glb_taken = (gc >= 2'd2);
        dir = (ch >= 2'd2) ? loc_taken : glb_taken;
        if (act == ACT_TRAIN)
        begin
            if (loc_taken == taken && glb_taken != taken)
            begin
                chooser[cidx] = step_ctr(ch, 1'b1);
            end
            else if (glb_taken == taken && loc_taken != taken)
            begin
                chooser[cidx] = step_ctr(ch, 1'b0);
            end
            global_ctr[gidx] = step_ctr(gc, taken);
            local_ctr[lh]    = step_ctr(lc, taken);
            local_hist[pidx] = {lh[LHB-2:0], taken};
            global_hist      = {global_hist[GHB-2:0], taken};
        end
        return dir;
    endfunction

    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
    end

    // Predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        logic exp_dir;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_dir_q.size() == 0)
            begin
                $error("prediction: expected none, got %0d", prediction);
                err_count++;
            end
            else
            begin
                exp_dir = expected_dir_q.pop_front();
                if (prediction !== exp_dir)
                begin
                    $error("prediction: expected %0d, got %0d", exp_dir, prediction);
                    err_count++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            expected_dir_q.push_back(predict_branch(action, pc, outcome));
        end
    end

    task automatic send_branch(input logic act, input logic [31:0] addr,
                               input logic taken);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        pc       <= addr;
        outcome  <= taken;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_dir_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_cold_tables();
        send_branch(ACT_PREDICT, 32'h0000_0000, NOT_TAKEN);
        send_branch(ACT_PREDICT, 32'hFFFF_FFFF, TAKEN);
    endtask

    // Train one branch taken repeatedly, then not taken repeatedly
    task automatic test_counter_saturation();
        repeat (6) send_branch(ACT_TRAIN, 32'h0000_0155, TAKEN);
        repeat (6) send_branch(ACT_TRAIN, 32'h0000_0155, NOT_TAKEN);
    endtask

    task automatic test_upper_pc_bits();
        send_branch(ACT_TRAIN, 32'hFFFF_F2AA, TAKEN);
        send_branch(ACT_TRAIN, 32'h0000_02AA, TAKEN);
        send_branch(ACT_PREDICT, 32'h8000_02AA, NOT_TAKEN);
    endtask

    // Outcome must be ignored when only predicting
    task automatic test_predict_only();
        send_branch(ACT_PREDICT, 32'h0000_0FFF, TAKEN);
        send_branch(ACT_PREDICT, 32'h0000_0FFF, TAKEN);
        send_branch(ACT_PREDICT, 32'h7FFF_F000, TAKEN);
    endtask

    // Mostly a few recurring branches with regular behavior, some noise
    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        int          slot;
        logic        act;
        logic        taken;
        logic [31:0] addr;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        for (int i = 0; i < HOT_BRANCHES; i++)
        begin
            hot_pc[i]   = $urandom_range(4095);
            hot_step[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 75)
            begin
                slot = $urandom_range(HOT_BRANCHES - 1);
                addr = ($urandom & 32'hFFFF_F000) | hot_pc[slot];
                act  = ($urandom_range(99) < 85) ? ACT_TRAIN : ACT_PREDICT;
                case (slot % 4)
                    0: taken = TAKEN;
                    1: taken = NOT_TAKEN;
                    2: taken = hot_step[slot][0];
                    default: taken = (hot_step[slot] % 3) != 2;
                endcase
                if ($urandom_range(99) < 8)
                begin
                    taken = ~taken;
                end
                if (act == ACT_TRAIN)
                begin
                    hot_step[slot]++;
                end
            end
            else
            begin
                addr  = $urandom;
                act   = 1'($urandom_range(1));
                taken = 1'($urandom_range(1));
            end
            send_branch(act, addr, taken);
        end
        wait_drained();
    endtask

    initial
    begin
        clear_tables();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_cold_tables();
        test_counter_saturation();
        test_upper_pc_bits();
        test_predict_only();
        wait_drained();

        test_random_traffic(240, 0, 0);
        test_random_traffic(235, 80, 0);
        test_random_traffic(235, 0, 80);
        test_random_traffic(240, 21, 21);

        repeat (10) @(posedge clk);
        if (err_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
